@@ rtl/pks_pkg.sv @@
// ----------------------------------------------------------------------------
// pks_pkg
// Types, constants and round functions shared by the key schedule modules.
// ----------------------------------------------------------------------------
package pks_pkg;

  localparam int KEY_W   = 80;
  localparam int MKEY_W  = 24;
  localparam int RKEY_W  = 24;
  localparam int SBOX_W  = 64;
  localparam int IDX_W   = 4;
  localparam int RNO_W   = 5;
  localparam int ROT_R   = 19;
  localparam int RKEY_LO = 16;
  localparam int RNO_LO  = 15;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [SBOX_W-1:0] sbox_t;

  function automatic logic [3:0] sbox_lookup(input sbox_t tbl, input logic [3:0] nib);
    return tbl[{nib, 2'b00} +: 4];
  endfunction

  function automatic key_t key_advance(input key_t k, input sbox_t tbl,
                                       input logic [RNO_W-1:0] rno);
    key_t r;
    r = {k[ROT_R-1:0], k[KEY_W-1:ROT_R]};
    r[KEY_W-1 -: 4] = sbox_lookup(tbl, r[KEY_W-1 -: 4]);
    r[RNO_LO +: RNO_W] = r[RNO_LO +: RNO_W] ^ rno;
    return r;
  endfunction

endpackage

@@ rtl/pks_cell.sv @@
// ----------------------------------------------------------------------------
// pks_cell
// One round stage: holds the key register for its round and hands the
// updated key to the next stage every cycle.
// ----------------------------------------------------------------------------
module pks_cell import pks_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_in,
  input  key_t  key_in,
  input  sbox_t sbox,
  output logic  vld_r,
  output key_t  key_r,
  output key_t  key_nxt
);

  localparam logic [RNO_W-1:0] RNO = RNO_W'(IDX + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_in;
  end

  assign key_nxt = key_advance(key_r, sbox, RNO);

endmodule

@@ rtl/present_key_schedule_24.sv @@
// ----------------------------------------------------------------------------
// present_key_schedule_24
// 80-bit key schedule for a 24-bit master key, one round key per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Write the packed S-box through cfg_we / cfg_wdata while the block is idle.
//   Start a transaction by raising start with in_master_key while busy is low.
//   The key then walks down a chain of ROUNDS round stages, one per cycle,
//   and each stage emits its round key through a single output register.
// Timing: an accepted key is first registered in stage 0; each stage's round
//   key is then registered in the output register before it reaches out_*. The
//   following keys come one per cycle, out_last_key marking the final one.
// A new master key can be accepted once the previous one has reached the last
//   stage; busy is high while a key still occupies any stage but the last.
// Each result is valid for the one cycle out_strobe is high; the receiver
//   cannot stall. Reset clears the valid bit of every stage, the output strobe and the S-box.
// ----------------------------------------------------------------------------
module present_key_schedule_24 import pks_pkg::*; #(
  parameter int ROUNDS = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SBOX_W-1:0] cfg_wdata,
  input  logic              start,
  input  logic [MKEY_W-1:0] in_master_key,
  output logic              busy,
  output logic              out_strobe,
  output logic [RKEY_W-1:0] out_round_key,
  output logic [IDX_W-1:0]  out_round_index,
  output logic              out_last_key
);

  localparam logic [ROUNDS-1:0] HEAD_MASK = ~(ROUNDS'(1) << (ROUNDS - 1));

  sbox_t             sbox_r;
  logic [ROUNDS-1:0] vld;
  key_t              cell_key [ROUNDS];
  key_t              chain_key [ROUNDS];
  logic [ROUNDS-1:0] chain_vld;
  logic [RKEY_W-1:0] sel_key;
  logic [IDX_W-1:0]  sel_idx;

  logic              out_strobe_r;
  logic [RKEY_W-1:0] out_round_key_r;
  logic [IDX_W-1:0]  out_round_index_r;
  logic              out_last_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbox_r <= '0;
    end else if (cfg_we) begin
      sbox_r <= cfg_wdata;
    end
  end

  assign busy         = |(vld & HEAD_MASK);
  assign chain_vld[0] = start & ~busy;
  assign chain_key[0] = {in_master_key, {(KEY_W - MKEY_W){1'b0}}};

  for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
    if (g == ROUNDS - 1) begin : g_last
      pks_cell #(.IDX(g)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (chain_vld[g]),
        .key_in  (chain_key[g]),
        .sbox    (sbox_r),
        .vld_r   (vld[g]),
        .key_r   (cell_key[g]),
        .key_nxt ()
      );
    end else begin : g_mid
      pks_cell #(.IDX(g)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .vld_in  (chain_vld[g]),
        .key_in  (chain_key[g]),
        .sbox    (sbox_r),
        .vld_r   (vld[g]),
        .key_r   (cell_key[g]),
        .key_nxt (chain_key[g+1])
      );
      assign chain_vld[g+1] = vld[g];
    end
  end

  always_comb begin
    sel_key = '0;
    sel_idx = '0;
    for (int i = 0; i < ROUNDS; i++) begin
      if (vld[i]) begin
        sel_key = sel_key | cell_key[i][RKEY_LO +: RKEY_W];
        sel_idx = sel_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= |vld;
    end
  end

  always_ff @(posedge clk) begin
    out_round_key_r   <= sel_key;
    out_round_index_r <= sel_idx;
    out_last_key_r    <= vld[ROUNDS-1];
  end

  assign out_strobe      = out_strobe_r;
  assign out_round_key   = out_round_key_r;
  assign out_round_index = out_round_index_r;
  assign out_last_key    = out_strobe_r & out_last_key_r;

  a_one_stage: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vld))
    else $error("more than one stage holds a key");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> vld[0])
    else $error("accepted key did not enter the first stage");

  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_key |=> out_strobe)
    else $error("round key run broken before the last key");

  a_no_chain_gap: assert property (@(posedge clk) disable iff (!rst_n)
    vld[0] |-> !busy || (ROUNDS > 1))
    else $error("stage chain state inconsistent");

endmodule

@@ bench/pks_round_key_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pks_round_key_checker
// Watches the key schedule's ports, predicts the round keys of every accepted
// master key with its own copy of the S-box and compares each strobed result,
// field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pks_round_key_checker import pks_pkg::*; #(
  parameter int ROUNDS = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SBOX_W-1:0] cfg_wdata,
  input  logic              start,
  input  logic              busy,
  input  logic [MKEY_W-1:0] in_master_key,
  input  logic              out_strobe,
  input  logic [RKEY_W-1:0] out_round_key,
  input  logic [IDX_W-1:0]  out_round_index,
  input  logic              out_last_key,
  output int                outstanding,
  output int                errors
);

  typedef struct packed {
    logic [RKEY_W-1:0] round_key;
    logic [IDX_W-1:0]  round_index;
    logic              last_key;
  } round_key_t;

  logic [SBOX_W-1:0] sbox_copy = '0;
  round_key_t        round_key_q[$];

  initial begin
    outstanding = 0;
    errors      = 0;
  end

  task automatic schedule_round_keys(input logic [MKEY_W-1:0] mk);
    logic [79:0] kreg;
    logic [3:0]  nib;
    logic [4:0]  rno;
    round_key_t  rk;
    int          r;
    kreg = {mk, 56'd0};
    for (r = 0; r < ROUNDS; r++) begin
      rk.round_key   = kreg[39:16];
      rk.round_index = IDX_W'(r);
      rk.last_key    = (r == ROUNDS - 1);
      round_key_q.push_back(rk);
      // left rotate by 61 == right rotate by 19
      kreg = (kreg >> 19) | (kreg << 61);
      nib = kreg[79:76];
      kreg[79:76] = 4'(sbox_copy >> (4 * nib));
      rno = 5'(r + 1);
      kreg[19:15] = kreg[19:15] ^ rno;
    end
  endtask

  always @(posedge clk) begin
    round_key_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (round_key_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual key %06h idx %0d last %0b",
                   $time, out_round_key, out_round_index, out_last_key);
          errors++;
        end else begin
          want = round_key_q.pop_front();
          if (out_round_key !== want.round_key) begin
            $display("%0t: round_key mismatch, expected %06h, actual %06h",
                     $time, want.round_key, out_round_key);
            errors++;
          end
          if (out_round_index !== want.round_index) begin
            $display("%0t: round_index mismatch, expected %0d, actual %0d",
                     $time, want.round_index, out_round_index);
            errors++;
          end
          if (out_last_key !== want.last_key) begin
            $display("%0t: last_key mismatch, expected %0b, actual %0b",
                     $time, want.last_key, out_last_key);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        schedule_round_keys(in_master_key);
      end
      if (cfg_we) begin
        sbox_copy = cfg_wdata;
      end
    end else begin
      sbox_copy = '0;
    end
    outstanding <= round_key_q.size();
  end

endmodule

@@ bench/tb_present_key_schedule_24.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_present_key_schedule_24
// Drives master keys into the key schedule over several S-box settings, with
// random idle gaps between transactions; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_present_key_schedule_24 import pks_pkg::*;;

  localparam int ROUNDS       = 11;
  localparam int PHASES       = 6;
  localparam int RAND_PER_PHS = 30;
  localparam int IDLE_LIMIT   = 2000;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              cfg_we          = 1'b0;
  logic [SBOX_W-1:0] cfg_wdata       = '0;
  logic              start           = 1'b0;
  logic [MKEY_W-1:0] in_master_key   = '0;
  logic              busy;
  logic              out_strobe;
  logic [RKEY_W-1:0] out_round_key;
  logic [IDX_W-1:0]  out_round_index;
  logic              out_last_key;
  int                outstanding;
  int                errors;
  int                idle_cycles     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  present_key_schedule_24 #(.ROUNDS(ROUNDS)) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .in_master_key   (in_master_key),
    .busy            (busy),
    .out_strobe      (out_strobe),
    .out_round_key   (out_round_key),
    .out_round_index (out_round_index),
    .out_last_key    (out_last_key)
  );

  pks_round_key_checker #(.ROUNDS(ROUNDS)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_master_key   (in_master_key),
    .out_strobe      (out_strobe),
    .out_round_key   (out_round_key),
    .out_round_index (out_round_index),
    .out_last_key    (out_last_key),
    .outstanding     (outstanding),
    .errors          (errors)
  );

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, ROUNDS + 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MKEY_W-1:0] pick_key();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0: return MKEY_W'(1) << $urandom_range(0, MKEY_W - 1);
      1: return ~(MKEY_W'(1) << $urandom_range(0, MKEY_W - 1));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return MKEY_W'($urandom);
    endcase
  endfunction

  task automatic send_key(input logic [MKEY_W-1:0] mk, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_master_key <= mk;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_sbox(input logic [SBOX_W-1:0] tbl);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= tbl;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [SBOX_W-1:0] sbox_set[PHASES];
    logic [MKEY_W-1:0] directed[6];
    bit                burst;
    int                p;
    int                i;
    sbox_set[0] = '0;                     // reset contents, not written
    sbox_set[1] = '1;
    sbox_set[2] = 64'hFEDCBA9876543210;   // identity
    sbox_set[3] = 64'h21748FE3DA09B65C;   // cipher S-box
    sbox_set[4] = {$urandom, $urandom};
    sbox_set[5] = '0;
    directed = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h000001, 24'hAAAAAA, 24'h555555};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < PHASES; p++) begin
      if (p > 0) write_sbox(sbox_set[p]);
      burst = (p % 3 == 2);
      if (p < 2) begin
        for (i = 0; i < 6; i++) send_key(directed[i], pick_gap(burst));
      end
      for (i = 0; i < RAND_PER_PHS; i++) send_key(pick_key(), pick_gap(burst));
      start <= 1'b0;
    end

    wait_drained();
    repeat (ROUNDS + 4) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, no transaction for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ present_key_schedule_24.f @@
rtl/pks_pkg.sv
rtl/pks_cell.sv
rtl/present_key_schedule_24.sv
bench/pks_round_key_checker.sv
bench/tb_present_key_schedule_24.sv
